[rtl/tspg_pkg.sv]
// Shared widths, scene geometry and colors for the test scene pixel generator.
// No dependencies; used by tspg_grad_div, test_scene_pixel_generator_top and the testbench.
package tspg_pkg;

    // Coordinate and register width (coordinates are bounded by 4096).
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 1;

    // Gradient divider: dividend is 40*y, quotient is below 40 for in-frame pixels.
    localparam int GRAD_SCALE = 40;
    localparam int REM_W      = 18;
    localparam int QUOT_W     = 6;

    // Bar width w/6 by reciprocal: (w * 2731) >> 14 is exact for 12-bit w.
    localparam int RECIP6    = 2731;
    localparam int RECIP_SH  = 14;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int BW_W      = 10;
    localparam int MUL_W     = COORD_W + 1;
    localparam int NUM_BARS  = 6;
    localparam int BAR_IDX_W = 3;

    // Panel geometry.
    localparam int PANEL_W    = 300;
    localparam int PANEL_H    = 180;
    localparam int PANEL_TOP  = 260;
    localparam int PANEL_EDGE = 3;
    localparam int LEFT_W     = 11;

    // Checkerboard and bar rows.
    localparam int CHK_TOP  = 110;
    localparam int CHK_BOT  = 210;
    localparam int BAR_TOP  = 20;
    localparam int BAR_BOT  = 80;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    // Colors (ARGB).
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [31:0] COL_BORDER   = 32'hff78b4ff;
    localparam logic [31:0] COL_INTERIOR = 32'hff181c28;
    localparam logic [31:0] COL_CHK_LITE = 32'hff3c3c46;
    localparam logic [31:0] COL_CHK_DARK = 32'hff1e1e26;
    localparam logic [7:0]  GRAD_RED     = 8'd8;
    localparam logic [7:0]  GRAD_GREEN   = 8'd12;
    localparam logic [7:0]  GRAD_BLUE0   = 8'd56;

    // Per-pixel layer decisions carried down the pipeline.
    typedef struct packed {
        logic                 in_frame;
        logic                 panel;
        logic                 edge_px;
        logic                 chk;
        logic                 chk_lite;
        logic                 bar_hit;
        logic [BAR_IDX_W-1:0] bar_idx;
    } t_layers;

    function automatic logic [31:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'hffdc3c3c;
            3'd1:    c = 32'hffdc9628;
            3'd2:    c = 32'hffdcdc3c;
            3'd3:    c = 32'hff3cc85a;
            3'd4:    c = 32'hff3c78dc;
            3'd5:    c = 32'hff9650d2;
            default: c = 32'h0;
        endcase
        return c;
    endfunction

endpackage

[rtl/test_scene_pixel_generator_top.sv]
// Test scene pixel generator: layered test scene color for each requested pixel.
// 5 register stages; 1 pixel/cycle while the output register is not stalled.
// The five register stages stall together when the output register holds an untaken result.
// The gradient divide runs as a 3-stage restoring divider (2 quotient bits per stage).
// Reset (synchronous, active low) empties the pipeline and loads width 640, height 480.
// Depends on tspg_pkg and tspg_grad_div.
module test_scene_pixel_generator_top import tspg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    // Pixel requests
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    // Pixel results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [31:0] color
    output logic                 m_axis_tuser    // [0] drawn
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_frame_width;
    logic [COORD_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together unless the output
    // register holds a result that is not taken this cycle.
    // ------------------------------------------------------------------
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign w_en          = !r_v5 || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: frame test, bar width (w/6 by reciprocal), panel left edge,
    // gradient dividend 40*y.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] w_x, w_y;
    logic [PROD_W-1:0]  w_bw_prod;
    logic               n_in1;
    logic [BW_W-1:0]    n_bw1;
    logic [LEFT_W-1:0]  n_left1;
    logic [REM_W-1:0]   n_dividend1;

    logic [COORD_W-1:0] r_x1, r_y1;
    logic               r_in1;
    logic [BW_W-1:0]    r_bw1;
    logic [LEFT_W-1:0]  r_left1;
    logic [REM_W-1:0]   r_dividend1;

    assign w_x = s_axis_tdata[COORD_W-1:0];
    assign w_y = s_axis_tdata[2*COORD_W-1:COORD_W];

    always_comb begin
        n_in1       = (w_x < r_frame_width) && (w_y < r_frame_height);
        w_bw_prod   = PROD_W'(r_frame_width) * PROD_W'(RECIP6);
        n_bw1       = BW_W'(w_bw_prod >> RECIP_SH);
        // Center the panel; pin it to the left edge on narrow frames.
        if (r_frame_width >= COORD_W'(PANEL_W)) begin
            n_left1 = LEFT_W'((r_frame_width - COORD_W'(PANEL_W)) >> 1);
        end else begin
            n_left1 = '0;
        end
        // 40*y as 32*y + 8*y
        n_dividend1 = (REM_W'(w_y) << 5) + (REM_W'(w_y) << 3);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1        <= w_x;
            r_y1        <= w_y;
            r_in1       <= n_in1;
            r_bw1       <= n_bw1;
            r_left1     <= n_left1;
            r_dividend1 <= n_dividend1;
        end
    end

    // Gradient quotient lands aligned with stage 4.
    logic [QUOT_W-1:0] w_grad_q;

    tspg_grad_div u_grad_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_dividend1),
        .i_divisor  (r_frame_height),
        .o_quot     (w_grad_q)
    );

    // ------------------------------------------------------------------
    // Stage 2: panel and checkerboard tests, bar boundaries k*bw.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] w_px, w_py, w_left, w_right;
    t_layers          n_lay2;
    logic             n_barzone2;
    logic [MUL_W-1:0] n_mul2 [NUM_BARS];

    t_layers          r_lay2;
    logic             r_barzone2;
    logic [COORD_W-1:0] r_x2;
    logic [MUL_W-1:0] r_mul2 [NUM_BARS];

    always_comb begin
        w_px    = MUL_W'(r_x1);
        w_py    = MUL_W'(r_y1);
        w_left  = MUL_W'(r_left1);
        w_right = w_left + MUL_W'(PANEL_W);

        n_lay2          = '0;
        n_lay2.in_frame = r_in1;
        n_lay2.panel    = (w_py >= MUL_W'(PANEL_TOP)) &&
                          (w_py <  MUL_W'(PANEL_TOP + PANEL_H)) &&
                          (w_px >= w_left) && (w_px < w_right);
        n_lay2.edge_px  = (w_px <  w_left + MUL_W'(PANEL_EDGE)) ||
                          (w_px >= w_right - MUL_W'(PANEL_EDGE)) ||
                          (w_py <  MUL_W'(PANEL_TOP + PANEL_EDGE)) ||
                          (w_py >= MUL_W'(PANEL_TOP + PANEL_H - PANEL_EDGE));
        n_lay2.chk      = (w_py >= MUL_W'(CHK_TOP)) && (w_py < MUL_W'(CHK_BOT));
        n_lay2.chk_lite = r_x1[4] ^ r_y1[4];

        // Bars only where the bar width is nonzero.
        n_barzone2 = (w_py >= MUL_W'(BAR_TOP)) && (w_py < MUL_W'(BAR_BOT)) &&
                     (r_bw1 != '0);
        for (int k = 0; k < NUM_BARS; k++) begin
            n_mul2[k] = MUL_W'(r_bw1) * MUL_W'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lay2     <= n_lay2;
            r_barzone2 <= n_barzone2;
            r_x2       <= r_x1;
            r_mul2     <= n_mul2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: bar index from the boundaries; past the sixth bar, no bar.
    // ------------------------------------------------------------------
    t_layers n_lay3;
    t_layers r_lay3;

    always_comb begin
        n_lay3         = r_lay2;
        n_lay3.bar_hit = 1'b0;
        n_lay3.bar_idx = '0;
        for (int k = NUM_BARS - 1; k >= 0; k--) begin
            if (MUL_W'(r_x2) < r_mul2[k]) begin
                n_lay3.bar_hit = r_barzone2;
                n_lay3.bar_idx = BAR_IDX_W'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: hold the layer decisions while the divider finishes.
    // ------------------------------------------------------------------
    t_layers r_lay4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lay3 <= n_lay3;
            r_lay4 <= r_lay3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5 (output register): pick the top layer that covers the pixel.
    // ------------------------------------------------------------------
    logic [7:0]  w_blue;
    logic [31:0] n_color5;
    logic [31:0] r_color5;
    logic        r_drawn5;

    assign w_blue = GRAD_BLUE0 - 8'(w_grad_q);

    always_comb begin
        if (!r_lay4.in_frame) begin
            n_color5 = '0;
        end else if (r_lay4.panel) begin
            n_color5 = r_lay4.edge_px ? COL_BORDER : COL_INTERIOR;
        end else if (r_lay4.chk) begin
            n_color5 = r_lay4.chk_lite ? COL_CHK_LITE : COL_CHK_DARK;
        end else if (r_lay4.bar_hit) begin
            n_color5 = bar_color(r_lay4.bar_idx);
        end else begin
            n_color5 = {ALPHA_OPAQUE, GRAD_RED, GRAD_GREEN, w_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_color5 <= n_color5;
            r_drawn5 <= r_lay4.in_frame;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_color5;
    assign m_axis_tuser  = r_drawn5;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A pixel outside the frame carries a zero color.
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("undrawn pixel with nonzero color");

    // Every drawn pixel is opaque.
    a_drawn_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:24] == ALPHA_OPAQUE)
        else $error("drawn pixel not opaque");

    // For an in-frame pixel y < h, so the gradient quotient stays below 40.
    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_lay4.in_frame |-> w_grad_q < QUOT_W'(GRAD_SCALE))
        else $error("gradient quotient out of range");

    // A stalled output stage freezes the stage feeding it.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !m_axis_tready |=> $stable(r_v4) && $stable(r_lay4))
        else $error("pipeline advanced during stall");

endmodule

[rtl/tspg_grad_div.sv]
// Pipelined restoring divider for the gradient term (40*y)/h, two quotient
// bits per stage. Depends on tspg_pkg.
module tspg_grad_div import tspg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [REM_W-1:0]   i_dividend,
    input  logic [COORD_W-1:0] i_divisor,
    output logic [QUOT_W-1:0]  o_quot
);

    localparam int STEPS      = 2;
    localparam int NUM_STAGES = QUOT_W / STEPS;

    logic [REM_W-1:0]  r_rem  [NUM_STAGES];
    logic [QUOT_W-1:0] r_quot [NUM_STAGES];

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        logic [REM_W-1:0]  w_src_rem;
        logic [QUOT_W-1:0] w_src_quot;
        logic [REM_W-1:0]  n_rem;
        logic [QUOT_W-1:0] n_quot;

        if (s == 0) begin : g_first
            assign w_src_rem  = i_dividend;
            assign w_src_quot = '0;
        end else begin : g_next
            assign w_src_rem  = r_rem[s-1];
            assign w_src_quot = r_quot[s-1];
        end

        // Subtract the shifted divisor where it fits, most significant bit first.
        always_comb begin
            logic [REM_W-1:0] d;
            int k;
            n_rem  = w_src_rem;
            n_quot = w_src_quot;
            for (int j = 0; j < STEPS; j++) begin
                k = QUOT_W - 1 - s * STEPS - j;
                d = REM_W'(i_divisor) << k;
                if (n_rem >= d) begin
                    n_rem     = n_rem - d;
                    n_quot[k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quot[s] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[NUM_STAGES-1];

endmodule

[tb/test_scene_pixel_generator_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the test scene pixel generator: pixel requests in, ARGB colors out.
// Depends on tspg_pkg and test_scene_pixel_generator_top; predicts each pixel's color itself.
module test_scene_pixel_generator_top_tb;
    import tspg_pkg::*;

    // Longest stretch with no handshake on either side before the run is called hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline depth plus margin: cycles to let pass before a register write and at the end.
    localparam int SETTLE_CYCLES  = 12;
    // The receiver holds off once, after this many results, for this many cycles.
    localparam int HOLD_AT_RESULT = 200;
    localparam int HOLD_CYCLES    = 200;
    localparam int MAX_GAP        = 11;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pixel_req;

    typedef struct {
        logic [31:0] color;
        logic        drawn;
    } t_pixel_result;

    // Bar colors, left to right.
    localparam logic [31:0] STRIPE_RGB [NUM_BARS] = '{
        32'hffdc3c3c, 32'hffdc9628, 32'hffdcdc3c,
        32'hff3cc85a, 32'hff3c78dc, 32'hff9650d2
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FRAME_WIDTH;
    logic [COORD_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [11:0] pixel_x, [23:12] pixel_y
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;        // [31:0] color
    logic                 m_axis_tuser;        // [0] drawn

    test_scene_pixel_generator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Frame size as the block currently holds it.
    int unsigned   cur_width  = RST_FRAME_WIDTH;
    int unsigned   cur_height = RST_FRAME_HEIGHT;

    t_pixel_req    pixel_req_q[$];       // requests waiting for the driver
    t_pixel_result expected_pixel_q[$];  // predicted colors, oldest first
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            no_idle = 1'b0;       // set for stretches where neither side idles

    // Flags set at the rising edge when a handshake completed on either side.
    logic          req_taken = 1'b0;
    logic          res_taken = 1'b0;

    // Color of one pixel in the layered scene for the current frame size.
    function automatic t_pixel_result predict_scene_pixel(int unsigned x, int unsigned y);
        t_pixel_result r;
        int unsigned   w;
        int unsigned   h;
        int unsigned   left;
        int unsigned   bar_w;
        bit            on_border;
        w = cur_width;
        h = cur_height;
        r.color = '0;
        r.drawn = 1'b0;
        // Outside the frame (this also covers a zero width or height): nothing drawn.
        if (x >= w || y >= h) return r;
        r.drawn = 1'b1;
        // Panel is centered; its left edge pins to column 0 on frames narrower than the panel.
        left = (w >= PANEL_W) ? (w - PANEL_W) / 2 : 0;
        if (y >= PANEL_TOP && y < PANEL_TOP + PANEL_H && x >= left && x < left + PANEL_W) begin
            on_border = (x < left + PANEL_EDGE) || (x >= left + PANEL_W - PANEL_EDGE) ||
                        (y < PANEL_TOP + PANEL_EDGE) || (y >= PANEL_TOP + PANEL_H - PANEL_EDGE);
            r.color = on_border ? COL_BORDER : COL_INTERIOR;
            return r;
        end
        if (y >= CHK_TOP && y < CHK_BOT) begin
            r.color = (((x >> 4) ^ (y >> 4)) & 1) ? COL_CHK_LITE : COL_CHK_DARK;
            return r;
        end
        // Bars vanish on narrow frames; columns past the sixth bar fall through.
        bar_w = w / NUM_BARS;
        if (y >= BAR_TOP && y < BAR_BOT && bar_w != 0 && x / bar_w < NUM_BARS) begin
            r.color = STRIPE_RGB[x / bar_w];
            return r;
        end
        r.color = {ALPHA_OPAQUE, GRAD_RED, GRAD_GREEN,
                   8'(GRAD_BLUE0 - (GRAD_SCALE * y) / h)};
        return r;
    endfunction

    // Mostly coordinates in and just around the frame, some anywhere, some aimed at layer rows.
    function automatic t_pixel_req random_pixel();
        t_pixel_req  p;
        int unsigned kind;
        int unsigned x_hi;
        int unsigned y_hi;
        kind = $urandom_range(0, 9);
        x_hi = (cur_width + 2 > 4095) ? 4095 : cur_width + 2;
        y_hi = (cur_height + 2 > 4095) ? 4095 : cur_height + 2;
        if (kind < 2) begin
            p.x = COORD_W'($urandom);
            p.y = COORD_W'($urandom);
        end else if (kind < 7) begin
            p.x = COORD_W'($urandom_range(0, x_hi));
            p.y = COORD_W'($urandom_range(0, y_hi));
        end else begin
            p.x = COORD_W'($urandom_range(0, x_hi));
            p.y = COORD_W'($urandom_range(BAR_TOP - 4, PANEL_TOP + PANEL_H + 4));
        end
        return p;
    endfunction

    task automatic queue_pixel(int unsigned x, int unsigned y);
        t_pixel_req p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        pixel_req_q.push_back(p);
    endtask

    // Hold until every request is sent and every result is back, then let the pipe settle.
    task automatic drain();
        while (pixel_req_q.size() != 0 || s_axis_tvalid || expected_pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both frame registers back to back; only called with the block idle.
    task automatic set_frame(int unsigned w, int unsigned h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= COORD_W'(w);
        @(posedge i_clk);
        cur_width = w;
        @(negedge i_clk);
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data  <= COORD_W'(h);
        @(posedge i_clk);
        cur_height = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int unsigned w, int unsigned h, int n, bit quiet);
        drain();
        set_frame(w, h);
        no_idle = quiet;
        repeat (n) pixel_req_q.push_back(random_pixel());
        drain();
        no_idle = 1'b0;
    endtask

    // Main sequence: reset, directed pixels at the reset frame size, then random phases.
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels for 640x480: panel spans columns 170..469, bars are 106 wide.
        queue_pixel(0, 0);
        queue_pixel(639, 479);
        queue_pixel(640, 0);        // just right of the frame
        queue_pixel(0, 480);        // just below the frame
        queue_pixel(4095, 4095);
        queue_pixel(170, 260);      // panel corner, border
        queue_pixel(173, 263);      // first interior pixel
        queue_pixel(469, 439);      // far panel corner
        queue_pixel(172, 300);      // left border, last column
        queue_pixel(466, 436);      // last interior pixel before the right and bottom borders
        queue_pixel(470, 300);      // right of panel: gradient
        queue_pixel(169, 350);      // left of panel: gradient
        queue_pixel(15, 110);       // checkerboard, dark cell
        queue_pixel(16, 110);       // checkerboard, light cell
        queue_pixel(16, 209);
        queue_pixel(100, 210);      // below the checkerboard: gradient
        queue_pixel(0, 20);         // first bar
        queue_pixel(105, 79);
        queue_pixel(106, 50);
        queue_pixel(212, 40);
        queue_pixel(318, 40);
        queue_pixel(424, 40);
        queue_pixel(530, 20);       // last bar
        queue_pixel(636, 50);       // past the last bar: gradient
        queue_pixel(50, 19);
        drain();

        // Run through frame sizes, the reset size and the extremes first; include a no-idle stretch at the end.
        run_random(640, 480, 150, 1'b0);
        run_random(4095, 4095, 100, 1'b0);
        run_random(1, 1, 30, 1'b0);
        run_random(0, 0, 25, 1'b0);
        run_random(0, 480, 15, 1'b0);
        run_random(640, 0, 15, 1'b0);
        run_random(5, 300, 40, 1'b0);
        run_random(299, 4095, 60, 1'b0);
        run_random(300, 500, 50, 1'b0);
        run_random(301, 220, 40, 1'b0);
        run_random(6, 100, 25, 1'b0);
        repeat (3) begin
            run_random($urandom_range(1, 4095), $urandom_range(1, 4095), 45, 1'b0);
        end
        run_random(640, 480, 80, 1'b1);

        drain();
        if (error_count == 0 && expected_pixel_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Rising edge: record handshakes, predict accepted requests, check results.
    always @(posedge i_clk) begin
        t_pixel_result want;
        req_taken <= s_axis_tvalid && s_axis_tready;
        res_taken <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_pixel_q.push_back(
                predict_scene_pixel(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixel_q.size() == 0) begin
                $error("result with no request outstanding: color %h drawn %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_pixel_q.pop_front();
                if (m_axis_tdata !== want.color) begin
                    $error("color mismatch: expected %h, got %h", want.color, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.drawn) begin
                    $error("drawn mismatch: expected %b, got %b", want.drawn, m_axis_tuser);
                    error_count++;
                end
            end
        end
        // Watchdog: count cycles where neither side moves.
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Request driver: present one request at a time, draw a gap after each accepted one.
    int         send_gap = 0;
    bit         send_busy = 1'b0;
    t_pixel_req send_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (send_busy && req_taken) begin
                send_busy = 1'b0;
                send_gap  = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pixel_req_q.size() != 0) begin
                    send_item = pixel_req_q.pop_front();
                    send_busy = 1'b1;
                end
            end
            s_axis_tvalid <= send_busy;
            // Hold the last request's data while idle so the bus never carries unknowns.
            if (send_busy) begin
                s_axis_tdata <= {send_item.y, send_item.x};
            end
        end
    end

    // Result receiver: may stall after each result; once, hold off long enough to back up input.
    int sink_wait = 0;
    int sink_count = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (res_taken) begin
                sink_count++;
                if (sink_count == HOLD_AT_RESULT) begin
                    sink_wait = HOLD_CYCLES;
                end else begin
                    sink_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

endmodule

[filelist.f]
rtl/tspg_pkg.sv
rtl/tspg_grad_div.sv
rtl/test_scene_pixel_generator_top.sv
tb/test_scene_pixel_generator_top_tb.sv
